FILE: hw/rtl/fsf_pkg.sv
// ----------------------------------------------------------------------------
// fsf_pkg
// Shared types and constants for the servo bus command framer.
// ----------------------------------------------------------------------------
package fsf_pkg;

    // command codes on the input channel
    localparam logic [1:0] ACT_MODE = 2'd0;
    localparam logic [1:0] ACT_MOVE = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // packet bytes
    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] INS_READ   = 8'd2;
    localparam logic [7:0] INS_WRITE  = 8'd3;
    localparam logic [7:0] ADDR_MODE  = 8'd33;
    localparam logic [7:0] ADDR_GOAL  = 8'd42;
    localparam logic [7:0] ADDR_POS   = 8'd56;
    localparam logic [7:0] READ_COUNT = 8'd2;
    localparam logic [7:0] LEN_SHORT  = 8'd4;
    localparam logic [7:0] LEN_LONG   = 8'd9;

    // position limit in ticks
    localparam logic [11:0] POS_MAX = 12'd4095;

    // byte index of the checksum for each packet size
    localparam logic [3:0] LAST_SHORT = 4'd7;
    localparam logic [3:0] LAST_LONG  = 4'd12;

    // byte index of the fields inside a packet
    localparam logic [3:0] IDX_HDR0 = 4'd0;
    localparam logic [3:0] IDX_HDR1 = 4'd1;
    localparam logic [3:0] IDX_ID   = 4'd2;
    localparam logic [3:0] IDX_LEN  = 4'd3;
    localparam logic [3:0] IDX_INS  = 4'd4;
    localparam logic [3:0] IDX_ADDR = 4'd5;
    localparam logic [3:0] IDX_PLO  = 4'd6;
    localparam logic [3:0] IDX_PHI  = 4'd7;

    // register map
    localparam logic REG_SERVO_ID = 1'b0;
    localparam logic [7:0] SERVO_ID_RESET = 8'd1;

    // default depth of the queue between front and back
    localparam int FSF_QUEUE_DEPTH = 2;

    // packet descriptor handed from front to back
    typedef struct packed {
        logic       long_pkt;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] ins;
        logic [7:0] addr;
        logic [7:0] p_lo;
        logic [7:0] p_hi;
        logic [7:0] chk;
    } t_desc;

endpackage

FILE: hw/rtl/fsf_front.sv
// ----------------------------------------------------------------------------
// fsf_front
// Classifies a command, clamps the move target and builds the packet
// descriptor with its checksum.
// ----------------------------------------------------------------------------
module fsf_front (
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_mode_value,
    input  logic signed [12:0] i_start_position,
    input  logic signed [13:0] i_offset,
    input  logic [7:0]         i_servo_id,
    output logic               o_push,
    output fsf_pkg::t_desc     o_desc,
    input  logic               i_q_ready
);
    import fsf_pkg::*;

    logic signed [14:0] sum_pos;
    logic [11:0]        target;
    logic               keep;
    logic [7:0]         byte_sum;
    t_desc              desc;

    // move target, clamped to the position range
    always_comb begin
        sum_pos = 15'(i_start_position) + 15'(i_offset);
        if (sum_pos[14]) begin
            target = '0;
        end else if (sum_pos > 15'sd4095) begin
            target = POS_MAX;
        end else begin
            target = sum_pos[11:0];
        end
    end

    // classification and descriptor build
    always_comb begin
        keep          = 1'b1;
        desc.long_pkt = 1'b0;
        desc.id       = i_servo_id;
        desc.len      = LEN_SHORT;
        desc.ins      = INS_WRITE;
        desc.addr     = ADDR_MODE;
        desc.p_lo     = i_mode_value;
        desc.p_hi     = 8'd0;
        case (i_action)
            ACT_MODE: begin
                keep = 1'b1;
            end
            ACT_MOVE: begin
                keep          = (i_start_position != -13'sd1);
                desc.long_pkt = 1'b1;
                desc.len      = LEN_LONG;
                desc.addr     = ADDR_GOAL;
                desc.p_lo     = target[7:0];
                desc.p_hi     = {4'd0, target[11:8]};
            end
            ACT_READ: begin
                desc.ins  = INS_READ;
                desc.addr = ADDR_POS;
                desc.p_lo = READ_COUNT;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        byte_sum = desc.id + desc.len + desc.ins + desc.addr + desc.p_lo + desc.p_hi;
        desc.chk = ~byte_sum;
    end

    // dropped commands are taken without a push
    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid & i_q_ready & keep;
    assign o_desc     = desc;

endmodule

FILE: hw/rtl/fsf_queue.sv
// ----------------------------------------------------------------------------
// fsf_queue
// Small descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module fsf_queue #(
    parameter int DEPTH = fsf_pkg::FSF_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fsf_pkg::t_desc i_desc,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output fsf_pkg::t_desc o_desc
);
    import fsf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en, rd_en;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign wr_en   = i_push & o_ready;
    assign rd_en   = i_pop & o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

FILE: hw/rtl/fsf_back.sv
// ----------------------------------------------------------------------------
// fsf_back
// Walks a packet descriptor and sends one byte per transfer through an
// output register.
// ----------------------------------------------------------------------------
module fsf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  fsf_pkg::t_desc i_q_desc,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_tx_byte,
    output logic           o_last
);
    import fsf_pkg::*;

    t_desc      r_desc;
    logic       r_busy;
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_tx_byte;
    logic       r_last;

    logic       advance;
    logic       at_end;
    logic       load;
    logic [3:0] last_idx;
    logic [7:0] cur_byte;

    assign last_idx = r_desc.long_pkt ? LAST_LONG : LAST_SHORT;
    assign at_end   = (r_idx == last_idx);
    assign advance  = r_busy & (~r_out_valid | i_out_ready);
    assign load     = ~r_busy | (advance & at_end);
    assign o_q_pop  = load;

    // byte at the current index
    always_comb begin
        if (at_end) begin
            cur_byte = r_desc.chk;
        end else begin
            case (r_idx)
                IDX_HDR0, IDX_HDR1: cur_byte = HDR_BYTE;
                IDX_ID:             cur_byte = r_desc.id;
                IDX_LEN:            cur_byte = r_desc.len;
                IDX_INS:            cur_byte = r_desc.ins;
                IDX_ADDR:           cur_byte = r_desc.addr;
                IDX_PLO:            cur_byte = r_desc.p_lo;
                IDX_PHI:            cur_byte = r_desc.p_hi;
                default:            cur_byte = 8'd0;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= i_q_valid;
            r_idx  <= '0;
        end else if (advance) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // active descriptor
    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_desc <= i_q_desc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_tx_byte <= cur_byte;
            r_last    <= at_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_last      = r_last;

endmodule

FILE: hw/rtl/servo_bus_command_framer_top.sv
// ----------------------------------------------------------------------------
// servo_bus_command_framer_top
// Turns servo commands into bus packets, one byte per output transfer.
// ----------------------------------------------------------------------------
// A command is taken whenever the descriptor queue has room; it is classified
// and checksummed in the same cycle and queued. The back end sends one byte
// per cycle while the output side keeps ready high: 8 bytes for a set running
// mode or position read packet, 13 for a move packet, with the next packet, if
// already queued, following without a gap. The byte sequencer sets the sustained
// rate, so a steady stream of moves runs at one command per 13-byte packet. A move
// with an unknown start position, and the unused command code, are taken and send
// nothing. servo_id sits at byte address 0 of the register port.
module servo_bus_command_framer_top #(
    parameter int QUEUE_DEPTH = fsf_pkg::FSF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_mode_value,
    input  logic signed [12:0] i_start_position,
    input  logic signed [13:0] i_offset,
    // byte channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_tx_byte,
    output logic               o_last,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fsf_pkg::*;

    logic [7:0] r_servo_id;
    logic       front_push;
    t_desc      front_desc;
    logic       q_ready;
    logic       q_valid;
    t_desc      q_desc;
    logic       q_pop;

    // register write and read back
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo_id <= SERVO_ID_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SERVO_ID) begin
            r_servo_id <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_SERVO_ID) ? {24'd0, r_servo_id} : 32'd0;

    // front end
    fsf_front u_front (
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_mode_value     (i_mode_value),
        .i_start_position (i_start_position),
        .i_offset         (i_offset),
        .i_servo_id       (r_servo_id),
        .o_push           (front_push),
        .o_desc           (front_desc),
        .i_q_ready        (q_ready)
    );

    // descriptor queue
    fsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_desc  (front_desc),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    // back end
    fsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_desc    (q_desc),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

endmodule
